// ===== rtl/murmur_hash_64_assert.svh =====
// Assertion macros shared by the murmur_hash_64 RTL.
// Needs a clock named clk and an active-low reset named arst_n in scope.
`ifndef MURMUR_HASH_64_ASSERT_SVH
`define MURMUR_HASH_64_ASSERT_SVH

// Same-cycle implication.
`define MH64_ASSERT_IMPL(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("murmur_hash_64 check failed");

// Next-cycle implication.
`define MH64_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("murmur_hash_64 check failed");

`endif

// ===== rtl/mh64_pkg.sv =====
// Constants, types and helpers for the murmur_hash_64 block.
// No dependencies; used by mh64_mul and murmur_hash_64.
package mh64_pkg;

	localparam int unsigned WORD_W   = 64;
	localparam int unsigned HALF_W   = WORD_W / 2;
	localparam int unsigned LEN_W    = 32;
	localparam int unsigned CNT_W    = 4;
	localparam int unsigned S_DATA_W = 104;

	localparam logic [WORD_W-1:0] MIX_MUL    = 64'hc6a4a7935bd1e995;
	localparam int unsigned       MIX_SHIFT  = 47;
	localparam logic [WORD_W-1:0] SEED_RESET = 64'h0000_0000_9747_b28c;

	typedef struct packed {
		logic              start;
		logic [WORD_W-1:0] operand;
	} mul_req_t;

	typedef struct packed {
		logic              done;
		logic [WORD_W-1:0] result;
	} mul_rsp_t;

	function automatic logic [WORD_W-1:0] xor_shift(input logic [WORD_W-1:0] v);
		return v ^ (v >> MIX_SHIFT);
	endfunction

	function automatic logic [WORD_W-1:0] tail_mask(input logic [2:0] nbytes);
		logic [5:0] sh;
		sh = {nbytes, 3'b000};
		return (64'd1 << sh) - 64'd1;
	endfunction

endpackage

// ===== rtl/mh64_mul.sv =====
// Shared multiplier: operand times MIX_MUL modulo 2^64 using one 32x32 multiplier.
// Four passes per product. Depends on mh64_pkg and murmur_hash_64_assert.svh.
`include "murmur_hash_64_assert.svh"

module mh64_mul (
	input  logic              clk,
	input  logic              arst_n,
	input  mh64_pkg::mul_req_t req,
	output mh64_pkg::mul_rsp_t rsp
);

	logic [mh64_pkg::WORD_W-1:0] a_q;
	logic [mh64_pkg::WORD_W-1:0] prod_q;
	logic [mh64_pkg::WORD_W-1:0] acc_q;
	logic                        busy_q;
	logic                        done_q;
	logic [1:0]                  step_q;
	logic [mh64_pkg::HALF_W-1:0] mul_a;
	logic [mh64_pkg::HALF_W-1:0] mul_b;

	// Partial products: a_lo*m_lo, a_hi*m_lo, a_lo*m_hi
	always_comb begin
		mul_a = (step_q == 2'd1) ? a_q[63:32] : a_q[31:0];
		mul_b = (step_q == 2'd2) ? mh64_pkg::MIX_MUL[63:32] : mh64_pkg::MIX_MUL[31:0];
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			a_q <= req.operand;
		end
		if (busy_q) begin
			prod_q <= mh64_pkg::WORD_W'(mul_a) * mh64_pkg::WORD_W'(mul_b);
			unique case (step_q)
				2'd0: acc_q <= acc_q;
				2'd1: acc_q <= prod_q;
				default: acc_q[63:32] <= acc_q[63:32] + prod_q[31:0];
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			step_q <= 2'd0;
		end else begin
			done_q <= busy_q && !req.start && (step_q == 2'd3);
			if (req.start) begin
				busy_q <= 1'b1;
				step_q <= 2'd0;
			end else if (busy_q) begin
				step_q <= step_q + 2'd1;
				if (step_q == 2'd3) begin
					busy_q <= 1'b0;
				end
			end
		end
	end

	assign rsp.done   = done_q;
	assign rsp.result = acc_q;

	`MH64_ASSERT_IMPL(a_no_restart, busy_q, !req.start)
	`MH64_ASSERT_IMPL(a_done_idle, done_q, !busy_q)
	`MH64_ASSERT_NEXT(a_done_after_last, busy_q && step_q == 2'd3 && !req.start, done_q)

endmodule

// ===== rtl/murmur_hash_64.sv =====
// MurmurHash64A over a stream of little-endian 64-bit words.
// Depends on mh64_pkg, mh64_mul and murmur_hash_64_assert.svh.
//
// Usage:
//   Write the seed through cfg_wr_en / cfg_wr_data while idle (reset value 0x9747b28c).
//   Each item on the s_axis side is one message word; s_axis_tlast marks the final
//   word, whose byte count (0..8) sets how many bytes count. The length field is
//   read on the first word of a message only.
//   One hash leaves on m_axis per message, after the final word.
// Sequencing:
//   Every 64-bit multiply runs on one shared 32x32 multiplier in four passes.
//   A middle word needs three multiplies, the first word of a message one more,
//   and a final word one, two or four multiplies before the output is loaded.
//   s_axis_tready is high only while the sequencer is idle,
//   one item in work at a time.
// Reset and stalls:
//   Reset clears the sequencer, drops m_axis_tvalid and restores the seed.
//   A finished hash waits in the output register; a second hash completing
//   before it is taken holds the sequencer until the register frees.
`include "murmur_hash_64_assert.svh"

module murmur_hash_64 (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_wr_en,
	input  logic [mh64_pkg::WORD_W-1:0]   cfg_wr_data,
	input  logic                          s_axis_tvalid,
	output logic                          s_axis_tready,
	// [63:0] data_word, [95:64] message_length, [99:96] byte_count, [103:100] zero
	input  logic [mh64_pkg::S_DATA_W-1:0] s_axis_tdata,
	input  logic                          s_axis_tlast,
	output logic                          m_axis_tvalid,
	input  logic                          m_axis_tready,
	// [63:0] hash_value
	output logic [mh64_pkg::WORD_W-1:0]   m_axis_tdata
);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SEED,
		ST_K1,
		ST_K2,
		ST_H,
		ST_FIN,
		ST_OUT
	} state_t;

	state_t                      state_q;
	state_t                      rt_state;
	logic [mh64_pkg::WORD_W-1:0] seed_q;
	logic [mh64_pkg::WORD_W-1:0] h_q;
	logic [mh64_pkg::WORD_W-1:0] k_q;
	logic [mh64_pkg::CNT_W-1:0]  cnt_q;
	logic                        last_q;
	logic                        inside_q;
	logic                        m_valid_q;
	logic [mh64_pkg::WORD_W-1:0] m_data_q;
	mh64_pkg::mul_req_t          mreq_q;
	mh64_pkg::mul_rsp_t          mrsp;

	logic                        s_accept;
	logic                        out_load;
	logic [mh64_pkg::WORD_W-1:0] in_word;
	logic [mh64_pkg::LEN_W-1:0]  in_len;
	logic [mh64_pkg::CNT_W-1:0]  in_cnt;
	logic [mh64_pkg::WORD_W-1:0] h_in;
	logic [mh64_pkg::WORD_W-1:0] k_in;
	logic [mh64_pkg::CNT_W-1:0]  cnt_in;
	logic                        last_in;
	logic                        full_in;
	logic                        tail_in;
	logic [mh64_pkg::WORD_W-1:0] rt_opnd;
	logic [mh64_pkg::WORD_W-1:0] res_x;

	assign in_word  = s_axis_tdata[63:0];
	assign in_len   = s_axis_tdata[95:64];
	assign in_cnt   = s_axis_tdata[99:96];
	assign s_accept = s_axis_tvalid && s_axis_tready;
	assign out_load = (state_q == ST_OUT) && (!m_valid_q || m_axis_tready);
	assign res_x    = mh64_pkg::xor_shift(mrsp.result);

	// Pick the first operation for a word once the starting hash is known
	always_comb begin
		if (state_q == ST_SEED) begin
			h_in    = seed_q ^ mrsp.result;
			k_in    = k_q;
			cnt_in  = cnt_q;
			last_in = last_q;
		end else begin
			h_in    = h_q;
			k_in    = in_word;
			cnt_in  = in_cnt;
			last_in = s_axis_tlast;
		end
		full_in = !last_in || (cnt_in >= 4'd8);
		tail_in = last_in && (cnt_in != 4'd0) && (cnt_in < 4'd8);
		if (full_in) begin
			rt_state = ST_K1;
			rt_opnd  = k_in;
		end else if (tail_in) begin
			rt_state = ST_H;
			rt_opnd  = h_in ^ (k_in & mh64_pkg::tail_mask(cnt_in[2:0]));
		end else begin
			rt_state = ST_FIN;
			rt_opnd  = mh64_pkg::xor_shift(h_in);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seed_q <= mh64_pkg::SEED_RESET;
		end else if (cfg_wr_en) begin
			seed_q <= cfg_wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= ST_IDLE;
			inside_q       <= 1'b0;
			m_valid_q      <= 1'b0;
			m_data_q       <= '0;
			mreq_q.start   <= 1'b0;
			mreq_q.operand <= '0;
			h_q            <= '0;
			k_q            <= '0;
			cnt_q          <= '0;
			last_q         <= 1'b0;
		end else begin
			mreq_q.start <= (state_q == ST_IDLE) ? s_accept :
				(mrsp.done && state_q != ST_FIN && !(state_q == ST_H && !last_q));
			if (out_load) begin
				m_valid_q <= 1'b1;
			end else if (m_valid_q && m_axis_tready) begin
				m_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (s_accept) begin
						k_q    <= in_word;
						cnt_q  <= in_cnt;
						last_q <= s_axis_tlast;
						if (!inside_q) begin
							state_q        <= ST_SEED;
							mreq_q.operand <= {{(mh64_pkg::WORD_W - mh64_pkg::LEN_W){1'b0}}, in_len};
						end else begin
							state_q        <= rt_state;
							mreq_q.operand <= rt_opnd;
							h_q            <= h_in;
						end
					end
				end
				ST_SEED: begin
					if (mrsp.done) begin
						state_q        <= rt_state;
						mreq_q.operand <= rt_opnd;
						h_q            <= h_in;
					end
				end
				ST_K1: begin
					if (mrsp.done) begin
						state_q        <= ST_K2;
						mreq_q.operand <= res_x;
					end
				end
				ST_K2: begin
					if (mrsp.done) begin
						state_q        <= ST_H;
						mreq_q.operand <= h_q ^ mrsp.result;
					end
				end
				ST_H: begin
					if (mrsp.done) begin
						if (last_q) begin
							state_q        <= ST_FIN;
							mreq_q.operand <= res_x;
						end else begin
							state_q  <= ST_IDLE;
							h_q      <= mrsp.result;
							inside_q <= 1'b1;
						end
					end
				end
				ST_FIN: begin
					if (mrsp.done) begin
						state_q <= ST_OUT;
						k_q     <= res_x;
					end
				end
				ST_OUT: begin
					if (out_load) begin
						m_data_q <= k_q;
						inside_q <= 1'b0;
						state_q  <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	mh64_mul u_mul (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (mreq_q),
		.rsp    (mrsp)
	);

	assign s_axis_tready = (state_q == ST_IDLE);
	assign m_axis_tvalid = m_valid_q;
	assign m_axis_tdata  = m_data_q;

	`MH64_ASSERT_IMPL(a_done_in_mul_state, mrsp.done,
		state_q == ST_SEED || state_q == ST_K1 || state_q == ST_K2 ||
		state_q == ST_H || state_q == ST_FIN)
	`MH64_ASSERT_NEXT(a_accept_busy, s_accept, state_q != ST_IDLE)
	`MH64_ASSERT_NEXT(a_out_loads, state_q == ST_OUT && !m_valid_q, m_valid_q)

endmodule
